@@ rtl/core/manipulator_mode_command_fsm_macros.svh @@
// Assertion macros shared by the mode command block.
`ifndef MANIPULATOR_MODE_COMMAND_FSM_MACROS_SVH
`define MANIPULATOR_MODE_COMMAND_FSM_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define MMCF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication check.
`define MMCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`else

`define MMCF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MMCF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/mmcf_pkg.sv @@
// Types and constants for the manipulator mode command block.
`timescale 1ns / 1ps

package mmcf_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_SPEED_DEFAULT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_SPEED_MIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_SPEED_MAX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MANUAL_SPEED       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MANUAL_ACCEL_TIME  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MANUAL_DECEL_TIME  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_ACCEL_TIME    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_DECEL_TIME    = 3'd7;

   // arbiter mode codes
   localparam logic [2:0] MODE_MANUAL = 3'd2;
   localparam logic [2:0] MODE_AUTO   = 3'd3;
   localparam logic [2:0] MODE_ERROR  = 3'd4;

   // arm state codes
   localparam logic [2:0] ST_BOOT       = 3'd0;
   localparam logic [2:0] ST_IDLE       = 3'd1;
   localparam logic [2:0] ST_MANUAL     = 3'd2;
   localparam logic [2:0] ST_AUTO_HOLD  = 3'd3;
   localparam logic [2:0] ST_AUTO_GO    = 3'd4;
   localparam logic [2:0] ST_ERROR_SAFE = 3'd5;

   localparam logic signed [15:0] ANGLE_HOLD_CODE = 16'sd32767;
   localparam logic [15:0]        DRIVE_POWER_MW  = 16'd1000;

   typedef struct packed {
      logic [15:0] auto_speed_default;
      logic [15:0] auto_speed_min;
      logic [15:0] auto_speed_max;
      logic [15:0] manual_speed;
      logic [15:0] manual_accel_time;
      logic [15:0] manual_decel_time;
      logic [15:0] auto_accel_time;
      logic [15:0] auto_decel_time;
   } cfg_type;

   typedef struct packed {
      logic [2:0]          mode;
      logic                estop;
      logic                torque_req;
      logic signed [15:0]  target_angle;
      logic [15:0]         speed_req;
      logic                vision_fresh;
      logic                servo_moving;
      logic [31:0]         now_ms;
   } req_type;

   typedef struct packed {
      logic                torque_en;
      logic signed [15:0]  command_angle;
      logic [15:0]         command_speed;
      logic [15:0]         accel_time;
      logic [15:0]         decel_time;
      logic [15:0]         drive_power;
      logic [2:0]          arm_state;
      logic [31:0]         state_entry_time;
   } rsp_type;

endpackage

@@ rtl/core/mmcf_csr.sv @@
// Configuration register file of the mode command block.
`timescale 1ns / 1ps

module mmcf_csr
   import mmcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wen,
   input  logic [CSR_IDX_W-1:0]  index,
   input  logic [CSR_DATA_W-1:0] wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wen) begin
         unique case (index)
            CSR_AUTO_SPEED_DEFAULT: cfg_in.auto_speed_default = wdata;
            CSR_AUTO_SPEED_MIN:     cfg_in.auto_speed_min     = wdata;
            CSR_AUTO_SPEED_MAX:     cfg_in.auto_speed_max     = wdata;
            CSR_MANUAL_SPEED:       cfg_in.manual_speed       = wdata;
            CSR_MANUAL_ACCEL_TIME:  cfg_in.manual_accel_time  = wdata;
            CSR_MANUAL_DECEL_TIME:  cfg_in.manual_decel_time  = wdata;
            CSR_AUTO_ACCEL_TIME:    cfg_in.auto_accel_time    = wdata;
            CSR_AUTO_DECEL_TIME:    cfg_in.auto_decel_time    = wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_speed_default <= 16'd30;
         cfg_ff.auto_speed_min     <= 16'd5;
         cfg_ff.auto_speed_max     <= 16'd90;
         cfg_ff.manual_speed       <= 16'd60;
         cfg_ff.manual_accel_time  <= 16'd100;
         cfg_ff.manual_decel_time  <= 16'd100;
         cfg_ff.auto_accel_time    <= 16'd200;
         cfg_ff.auto_decel_time    <= 16'd200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/mmcf_cmd.sv @@
// Arm state registers and the command decode for one request.
`timescale 1ns / 1ps
`include "manipulator_mode_command_fsm_macros.svh"

module mmcf_cmd
   import mmcf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type req,
   input  logic    advance,
   output rsp_type result
);

   logic [2:0]         state_ff;
   logic [2:0]         state_in;
   logic [31:0]        entry_time_ff;
   logic [31:0]        entry_time_in;
   logic signed [15:0] last_angle_ff;
   logic signed [15:0] last_angle_in;

   logic        fault;
   logic        is_hold;
   logic [15:0] speed_raised;
   logic [15:0] speed_clamped;
   logic [15:0] auto_speed;
   logic        state_change;
   logic        stamp_due;
   logic        quiet_state;
   logic        quiet_cmd;

   assign fault   = req.estop || (req.mode == MODE_ERROR);
   assign is_hold = (req.target_angle == ANGLE_HOLD_CODE);

   // raise to min first, then cap at max; max wins when the limits cross
   assign speed_raised  = (req.speed_req < cfg.auto_speed_min) ?
                          cfg.auto_speed_min : req.speed_req;
   assign speed_clamped = (speed_raised > cfg.auto_speed_max) ?
                          cfg.auto_speed_max : speed_raised;
   assign auto_speed    = (req.speed_req == 16'd0) ?
                          cfg.auto_speed_default : speed_clamped;

   always_comb begin
      state_in              = state_ff;
      last_angle_in         = last_angle_ff;
      result.torque_en      = 1'b0;
      result.command_speed  = 16'd0;
      result.accel_time     = 16'd0;
      result.decel_time     = 16'd0;
      result.drive_power    = 16'd0;
      if (fault) begin
         state_in = ST_ERROR_SAFE;
      end else begin
         unique case (req.mode)
            MODE_MANUAL: begin
               state_in             = ST_MANUAL;
               result.torque_en     = req.torque_req;
               result.command_speed = cfg.manual_speed;
               result.accel_time    = cfg.manual_accel_time;
               result.decel_time    = cfg.manual_decel_time;
               result.drive_power   = DRIVE_POWER_MW;
               if (!is_hold) begin
                  last_angle_in = req.target_angle;
               end
            end
            MODE_AUTO: begin
               result.torque_en     = req.torque_req;
               result.command_speed = auto_speed;
               result.accel_time    = cfg.auto_accel_time;
               result.decel_time    = cfg.auto_decel_time;
               result.drive_power   = DRIVE_POWER_MW;
               if (req.vision_fresh && !is_hold) begin
                  last_angle_in = req.target_angle;
                  state_in      = req.servo_moving ? ST_AUTO_GO : ST_AUTO_HOLD;
               end else begin
                  state_in = ST_AUTO_HOLD;
               end
            end
            default: begin
               // init, idle and undefined modes all settle in idle
               state_in = ST_IDLE;
            end
         endcase
      end
      // recovery through idle happens at the same tick, so only the final
      // state matters for the entry time
      state_change            = (state_in != state_ff);
      entry_time_in           = state_change ? req.now_ms : entry_time_ff;
      result.command_angle    = last_angle_in;
      result.arm_state        = state_in;
      result.state_entry_time = entry_time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_BOOT;
         entry_time_ff <= 32'd0;
         last_angle_ff <= 16'sd0;
      end else if (advance) begin
         state_ff      <= state_in;
         entry_time_ff <= entry_time_in;
         last_angle_ff <= last_angle_in;
      end
   end

   assign stamp_due   = advance && state_change;
   assign quiet_state = (state_in == ST_ERROR_SAFE) || (state_in == ST_IDLE);
   assign quiet_cmd   = !result.torque_en && (result.drive_power == 16'd0);

   `MMCF_ASSERT_NEXT(a_fault_to_safe, clock, reset, advance && fault, state_ff == ST_ERROR_SAFE)
   `MMCF_ASSERT_NEXT(a_no_boot_after_req, clock, reset, advance, state_ff != ST_BOOT)
   `MMCF_ASSERT_NEXT(a_entry_stamp, clock, reset, stamp_due, entry_time_ff == $past(req.now_ms))
   `MMCF_ASSERT_IMPLIES(a_safe_no_torque, clock, reset, quiet_state, quiet_cmd)

endmodule

@@ rtl/core/manipulator_mode_command_fsm.sv @@
// Top level of the manipulator mode command block.
`timescale 1ns / 1ps

// Turns one arbiter request per cycle into one servo motion command plus the
// arm state and the tick at which that state was entered. A request is taken
// into an input register, decoded combinationally against the arm state
// registers, and the command lands in a result register; a new request is
// taken every cycle while the result side keeps up. The arm state, entry
// tick and last angle update as a request leaves the input register.
// Configuration writes take effect on the next cycle.
module manipulator_mode_command_fsm
   import mmcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_mode,
   input  logic                  req_estop,
   input  logic                  req_torque_req,
   input  logic signed [15:0]    req_target_angle,
   input  logic [15:0]           req_speed_req,
   input  logic                  req_vision_fresh,
   input  logic                  req_servo_moving,
   input  logic [31:0]           req_now_ms,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_torque_en,
   output logic signed [15:0]    rsp_command_angle,
   output logic [15:0]           rsp_command_speed,
   output logic [15:0]           rsp_accel_time,
   output logic [15:0]           rsp_decel_time,
   output logic [15:0]           rsp_drive_power,
   output logic [2:0]            rsp_arm_state,
   output logic [31:0]           rsp_state_entry_time
);

   cfg_type cfg;
   req_type req_ff;
   req_type req_in;
   logic    req_valid_ff;
   logic    req_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   rsp_type result;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    advance;
   logic    take;

   mmcf_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wen   (csr_wen),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   mmcf_cmd u_cmd (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req_ff),
      .advance (advance),
      .result  (result)
   );

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff;
      if (take) begin
         req_in.mode           = req_mode;
         req_in.estop          = req_estop;
         req_in.torque_req     = req_torque_req;
         req_in.target_angle   = req_target_angle;
         req_in.speed_req      = req_speed_req;
         req_in.vision_fresh   = req_vision_fresh;
         req_in.servo_moving   = req_servo_moving;
         req_in.now_ms         = req_now_ms;
         req_valid_in          = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_torque_en        = rsp_ff.torque_en;
   assign rsp_command_angle    = rsp_ff.command_angle;
   assign rsp_command_speed    = rsp_ff.command_speed;
   assign rsp_accel_time       = rsp_ff.accel_time;
   assign rsp_decel_time       = rsp_ff.decel_time;
   assign rsp_drive_power      = rsp_ff.drive_power;
   assign rsp_arm_state        = rsp_ff.arm_state;
   assign rsp_state_entry_time = rsp_ff.state_entry_time;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the manipulator mode command state machine.
`timescale 1ns / 1ps

module tb_top
   import mmcf_pkg::*;
;

   // mode codes that the package leaves unnamed
   localparam logic [2:0] MODE_INIT   = 3'd0;
   localparam logic [2:0] MODE_IDLE   = 3'd1;
   localparam logic [2:0] MODE_RSVD_A = 3'd5;
   localparam logic [2:0] MODE_RSVD_C = 3'd7;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 305;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_cur = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_torque_en;
   logic signed [15:0]  rsp_command_angle;
   logic [15:0]         rsp_command_speed;
   logic [15:0]         rsp_accel_time;
   logic [15:0]         rsp_decel_time;
   logic [15:0]         rsp_drive_power;
   logic [2:0]          rsp_arm_state;
   logic [31:0]         rsp_state_entry_time;

   // predictor state and its copy of the settings
   cfg_type            set_cfg;
   logic [2:0]         arm_st = ST_BOOT;
   logic [31:0]        entry_tick = '0;
   logic signed [15:0] held_angle = '0;

   req_type     intent_q[$];
   rsp_type     cmd_due_q[$];
   logic [31:0] tick = '0;
   logic        req_took = 1'b0;
   int unsigned snd_idle_pct = 27;
   int unsigned rsp_stall_pct = 83;
   int unsigned mismatches = 0;
   int unsigned stall_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   manipulator_mode_command_fsm u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_wen              (csr_wen),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_cur.mode),
      .req_estop            (req_cur.estop),
      .req_torque_req       (req_cur.torque_req),
      .req_target_angle     (req_cur.target_angle),
      .req_speed_req        (req_cur.speed_req),
      .req_vision_fresh     (req_cur.vision_fresh),
      .req_servo_moving     (req_cur.servo_moving),
      .req_now_ms           (req_cur.now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_torque_en        (rsp_torque_en),
      .rsp_command_angle    (rsp_command_angle),
      .rsp_command_speed    (rsp_command_speed),
      .rsp_accel_time       (rsp_accel_time),
      .rsp_decel_time       (rsp_decel_time),
      .rsp_drive_power      (rsp_drive_power),
      .rsp_arm_state        (rsp_arm_state),
      .rsp_state_entry_time (rsp_state_entry_time)
   );

   // ---------------- predictor ----------------

   function automatic void move_to_state(logic [2:0] st, logic [31:0] now);
      if (arm_st != st) begin
         arm_st = st;
         entry_tick = now;
      end
   endfunction

   function automatic logic [15:0] clamp_auto_speed(logic [15:0] want);
      logic [15:0] v;
      if (want == 16'd0) return set_cfg.auto_speed_default;
      v = want;
      if (v < set_cfg.auto_speed_min) v = set_cfg.auto_speed_min;
      // max wins when the limits are inverted
      if (v > set_cfg.auto_speed_max) v = set_cfg.auto_speed_max;
      return v;
   endfunction

   function automatic rsp_type next_command(req_type r);
      rsp_type c;
      c = '0;
      if (r.estop || r.mode == MODE_ERROR) begin
         move_to_state(ST_ERROR_SAFE, r.now_ms);
      end else begin
         if (arm_st == ST_ERROR_SAFE || arm_st == ST_BOOT) move_to_state(ST_IDLE, r.now_ms);
         if (r.mode == MODE_MANUAL) begin
            move_to_state(ST_MANUAL, r.now_ms);
            if (r.target_angle != ANGLE_HOLD_CODE) held_angle = r.target_angle;
            c.torque_en     = r.torque_req;
            c.command_speed = set_cfg.manual_speed;
            c.accel_time    = set_cfg.manual_accel_time;
            c.decel_time    = set_cfg.manual_decel_time;
            c.drive_power   = DRIVE_POWER_MW;
         end else if (r.mode == MODE_AUTO) begin
            c.torque_en     = r.torque_req;
            c.command_speed = clamp_auto_speed(r.speed_req);
            c.accel_time    = set_cfg.auto_accel_time;
            c.decel_time    = set_cfg.auto_decel_time;
            c.drive_power   = DRIVE_POWER_MW;
            if (r.vision_fresh && r.target_angle != ANGLE_HOLD_CODE) begin
               held_angle = r.target_angle;
               move_to_state(r.servo_moving ? ST_AUTO_GO : ST_AUTO_HOLD, r.now_ms);
            end else begin
               move_to_state(ST_AUTO_HOLD, r.now_ms);
            end
         end else begin
            move_to_state(ST_IDLE, r.now_ms);
         end
      end
      c.command_angle    = held_angle;
      c.arm_state        = arm_st;
      c.state_entry_time = entry_tick;
      return c;
   endfunction

   // ---------------- driver ----------------

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (intent_q.size() != 0 && $urandom_range(99, 0) >= snd_idle_pct) begin
            req_cur   <= intent_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   // ---------------- monitor, checker, watchdog ----------------

   task automatic report_field(string what, logic [31:0] want_v, logic [31:0] got_v);
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want_v, got_v);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      req_took <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) cmd_due_q.push_back(next_command(req_cur));
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_torque_en, rsp_command_angle, rsp_command_speed, rsp_accel_time,
                 rsp_decel_time, rsp_drive_power, rsp_arm_state, rsp_state_entry_time};
         if (cmd_due_q.size() == 0) begin
            $display("%0t: command out with no request pending", $time);
            mismatches++;
         end else begin
            want = cmd_due_q.pop_front();
            if (got.torque_en !== want.torque_en)
               report_field("torque_en", 32'(want.torque_en), 32'(got.torque_en));
            if (got.command_angle !== want.command_angle)
               report_field("command_angle", 32'(want.command_angle),
                            32'(got.command_angle));
            if (got.command_speed !== want.command_speed)
               report_field("command_speed", 32'(want.command_speed),
                            32'(got.command_speed));
            if (got.accel_time !== want.accel_time)
               report_field("accel_time", 32'(want.accel_time), 32'(got.accel_time));
            if (got.decel_time !== want.decel_time)
               report_field("decel_time", 32'(want.decel_time), 32'(got.decel_time));
            if (got.drive_power !== want.drive_power)
               report_field("drive_power", 32'(want.drive_power), 32'(got.drive_power));
            if (got.arm_state !== want.arm_state)
               report_field("arm_state", 32'(want.arm_state), 32'(got.arm_state));
            if (got.state_entry_time !== want.state_entry_time)
               report_field("state_entry_time", want.state_entry_time,
                            got.state_entry_time);
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress", $time);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   task automatic queue_intent(req_type r);
      r.now_ms = tick;
      tick += $urandom_range(30, 0);
      intent_q.push_back(r);
   endtask

   task automatic intent(logic [2:0] mode, logic estop, logic torque,
                         logic signed [15:0] angle, logic [15:0] speed,
                         logic fresh, logic moving);
      queue_intent('{mode, estop, torque, angle, speed, fresh, moving, 32'd0});
   endtask

   task automatic random_request();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (pick < 40) r.mode = MODE_MANUAL;
      else if (pick < 80) r.mode = MODE_AUTO;
      else if (pick < 87) r.mode = MODE_IDLE;
      else if (pick < 90) r.mode = MODE_INIT;
      else if (pick < 94) r.mode = 3'($urandom_range(MODE_RSVD_C, MODE_RSVD_A));
      else r.mode = MODE_ERROR;
      r.estop      = ($urandom_range(99, 0) < 4);
      r.torque_req = ($urandom_range(99, 0) < 80);
      pick = $urandom_range(99, 0);
      if (pick < 15) r.target_angle = ANGLE_HOLD_CODE;
      else if (pick < 20) r.target_angle = 16'sh8000;
      else if (pick < 25) r.target_angle = ANGLE_HOLD_CODE - 16'sd1;
      else if (pick < 60) r.target_angle = 16'($urandom_range(360, 0) - 180);
      else r.target_angle = 16'($urandom_range(65535, 0));
      pick = $urandom_range(99, 0);
      if (pick < 20) r.speed_req = '0;
      else if (pick < 50) r.speed_req = 16'($urandom_range(127, 1));
      else if (pick < 60) r.speed_req = 16'hFFFF;
      else r.speed_req = 16'($urandom_range(65535, 0));
      r.vision_fresh = ($urandom_range(99, 0) < 70);
      r.servo_moving = 1'($urandom_range(1, 0));
      // occasional jump of the tick, covers the upper bits
      if ($urandom_range(99, 0) < 8) tick = $urandom();
      queue_intent(r);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic drain();
      while (intent_q.size() != 0 || req_valid || cmd_due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      cfg_type next_cfg;
      set_cfg = '{16'd30, 16'd5, 16'd90, 16'd60, 16'd100, 16'd100, 16'd200, 16'd200};

      // directed: leave boot, manual, auto corners, clamp edges, e-stop, recovery
      intent(MODE_IDLE,   1'b0, 1'b1, 16'sd0,          16'd0,     1'b0, 1'b0);
      intent(MODE_INIT,   1'b0, 1'b1, 16'sd5,          16'd0,     1'b1, 1'b1);
      intent(MODE_MANUAL, 1'b0, 1'b1, 16'sd100,        16'd0,     1'b0, 1'b0);
      intent(MODE_MANUAL, 1'b0, 1'b1, ANGLE_HOLD_CODE, 16'd7,     1'b0, 1'b1);
      intent(MODE_MANUAL, 1'b0, 1'b0, 16'sh8000,       16'hFFFF,  1'b1, 1'b0);
      intent(MODE_AUTO,   1'b0, 1'b1, 16'sd45,         16'd50,    1'b1, 1'b1);
      intent(MODE_AUTO,   1'b0, 1'b1, 16'sd46,         16'd50,    1'b1, 1'b0);
      intent(MODE_AUTO,   1'b0, 1'b1, 16'sd10,         16'd50,    1'b0, 1'b1);
      intent(MODE_AUTO,   1'b0, 1'b1, ANGLE_HOLD_CODE, 16'd50,    1'b1, 1'b1);
      intent(MODE_AUTO,   1'b0, 1'b1, 16'sd20,         16'd0,     1'b1, 1'b1);
      intent(MODE_AUTO,   1'b0, 1'b0, 16'sd21,         16'd1,     1'b1, 1'b0);
      intent(MODE_AUTO,   1'b0, 1'b1, -16'sd90,        16'hFFFF,  1'b1, 1'b1);
      intent(MODE_MANUAL, 1'b1, 1'b1, 16'sd30,         16'd0,     1'b1, 1'b1);
      intent(MODE_AUTO,   1'b1, 1'b1, 16'sd31,         16'd0,     1'b1, 1'b1);
      intent(MODE_ERROR,  1'b0, 1'b1, 16'sd32,         16'd0,     1'b1, 1'b1);
      intent(MODE_MANUAL, 1'b0, 1'b1, 16'sd33,         16'd0,     1'b0, 1'b0);
      intent(MODE_ERROR,  1'b0, 1'b0, 16'sd34,         16'd0,     1'b0, 1'b0);
      intent(MODE_IDLE,   1'b0, 1'b0, 16'sd35,         16'd0,     1'b0, 1'b0);
      intent(MODE_RSVD_A, 1'b0, 1'b1, 16'sd36,         16'd0,     1'b1, 1'b1);
      intent(MODE_AUTO,   1'b0, 1'b1, 16'sd37,         16'd0,     1'b1, 1'b1);
      intent(MODE_RSVD_C, 1'b0, 1'b1, 16'sd38,         16'd0,     1'b1, 1'b1);
      intent(MODE_MANUAL, 1'b0, 1'b0, 16'sd32766,      16'd0,     1'b0, 1'b0);
      tick = '1;
      intent(MODE_AUTO,   1'b0, 1'b0, 16'sd39,         16'd9,     1'b0, 1'b1);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: next_cfg = '{16'($urandom_range(200, 0)), 16'($urandom_range(40, 1)),
                            16'($urandom_range(400, 60)), 16'($urandom_range(65535, 0)),
                            16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
                            16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0))};
            1: next_cfg = '0;
            2: next_cfg = '1;
            // min above max
            3: next_cfg = '{16'd0, 16'd200, 16'd20, 16'd1, 16'd65535, 16'd0,
                            16'd1, 16'd65534};
            4: next_cfg = {$urandom(), $urandom(), $urandom(), $urandom()};
            default: next_cfg = '{16'd65535, 16'd0, 16'd65535, 16'd123, 16'd0,
                                  16'd65535, 16'd65535, 16'd0};
         endcase
         write_reg(CSR_AUTO_SPEED_DEFAULT, next_cfg.auto_speed_default);
         write_reg(CSR_AUTO_SPEED_MIN,     next_cfg.auto_speed_min);
         write_reg(CSR_AUTO_SPEED_MAX,     next_cfg.auto_speed_max);
         write_reg(CSR_MANUAL_SPEED,       next_cfg.manual_speed);
         write_reg(CSR_MANUAL_ACCEL_TIME,  next_cfg.manual_accel_time);
         write_reg(CSR_MANUAL_DECEL_TIME,  next_cfg.manual_decel_time);
         write_reg(CSR_AUTO_ACCEL_TIME,    next_cfg.auto_accel_time);
         write_reg(CSR_AUTO_DECEL_TIME,    next_cfg.auto_decel_time);
         @(negedge clock);
         csr_wen <= 1'b0;
         set_cfg = next_cfg;
         @(negedge clock);
         if (ph < 2) begin
            snd_idle_pct  = 27;
            rsp_stall_pct = 83;
         end else if (ph < 4) begin
            snd_idle_pct  = 83;
            rsp_stall_pct = 27;
         end else begin
            snd_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         repeat (PHASE_ITEMS) random_request();
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && cmd_due_q.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/mmcf_pkg.sv
rtl/core/mmcf_csr.sv
rtl/core/mmcf_cmd.sv
rtl/core/manipulator_mode_command_fsm.sv
tb/tb_top.sv
